FILE: rtl/core/es2cd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package es2cd_pkg;

  // Shared divide unit widths. Every dividend fits in DIV_W bits, and each
  // reciprocal is floor(2**REC_SH / divisor) with REC_SH no smaller than DIV_W.
  localparam int unsigned DIV_W  = 26;
  localparam int unsigned DSR_W  = 18;
  localparam int unsigned REC_W  = 24;
  localparam int unsigned REC_SH = 26;
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned RMD_W  = 18;

  // Month indexes used by the month scan: February, the 30-day months, and the first and last months.
  localparam logic [3:0] MON_JAN = 4'd0;
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;
  localparam logic [3:0] MON_DEC = 4'd11;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
    logic [REC_W-1:0] recip;  // scaled reciprocal of the divisor
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
    logic [RMD_W-1:0] rmd;
  } div_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (mon == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP || mon == MON_NOV) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/epoch_seconds_to_calendar_date_top.sv
// Converts a signed 32-bit count of seconds since 1970-01-01 00:00:00 into
// broken-down calendar time (second, minute, hour, weekday, day of year,
// year minus 1900, month, day of month); times before 1970 are floored, so
// every field stays in range. One word is converted at a time: after a word
// is accepted, in_ready_o stays low until the result word has been taken.
// After acceptance, eight constant divisions run back to back on one
// shared reciprocal-multiply divide unit, then the year arithmetic state,
// then a month scan with one step per month passed plus one; out_valid_o
// then rises. in_ready_o is high again right after the result word is
// taken.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_date_top
  import es2cd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] epoch_seconds_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [5:0]              second_o,
  output logic [5:0]              minute_o,
  output logic [4:0]              hour_o,
  output logic [2:0]              weekday_o,
  output logic [8:0]              day_of_year_o,
  output logic [7:0]              years_since_1900_o,
  output logic [3:0]              month_o,
  output logic [4:0]              day_of_month_o
);

  // Sequencer states. Each division state waits for the divider to finish.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DAY  = 4'd1;
  localparam logic [3:0] S_MIN  = 4'd2;
  localparam logic [3:0] S_HR   = 4'd3;
  localparam logic [3:0] S_WD   = 4'd4;
  localparam logic [3:0] S_Y1   = 4'd5;
  localparam logic [3:0] S_Y2   = 4'd6;
  localparam logic [3:0] S_Y3   = 4'd7;
  localparam logic [3:0] S_Y4   = 4'd8;
  localparam logic [3:0] S_YDAY = 4'd9;
  localparam logic [3:0] S_MON  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // Adding 24856 days of seconds makes every input non-negative, so the
  // divisions below are plain unsigned ones and flooring comes for free.
  localparam logic [32:0]      SEC_OFFSET = 33'd2147558400;
  // Shifted day count plus this gives days since 1601-01-01.
  localparam logic [17:0]      DAY_BASE   = 18'd109918;
  // The shifted day count is 2 mod 7 ahead of 1970's Thursday offset.
  localparam logic [DIV_W-1:0] WD_ADJ     = DIV_W'(5);

  // Divisors and their reciprocals scaled by 2**REC_SH. A day is 675 times
  // 128 seconds, so the low seven bits bypass the day division.
  localparam logic [DSR_W-1:0] DSR_DAY  = DSR_W'(675);
  localparam logic [REC_W-1:0] REC_DAY  = REC_W'(99420);
  localparam logic [DSR_W-1:0] DSR_60   = DSR_W'(60);
  localparam logic [REC_W-1:0] REC_60   = REC_W'(1118481);
  localparam logic [DSR_W-1:0] DSR_WD   = DSR_W'(7);
  localparam logic [REC_W-1:0] REC_WD   = REC_W'(9586980);
  localparam logic [DSR_W-1:0] DSR_4Y   = DSR_W'(1460);
  localparam logic [REC_W-1:0] REC_4Y   = REC_W'(45964);
  localparam logic [DSR_W-1:0] DSR_100Y = DSR_W'(36500);
  localparam logic [REC_W-1:0] REC_100Y = REC_W'(1838);
  localparam logic [DSR_W-1:0] DSR_400Y = DSR_W'(146000);
  localparam logic [REC_W-1:0] REC_400Y = REC_W'(459);
  localparam logic [DSR_W-1:0] DSR_YEAR = DSR_W'(365);
  localparam logic [REC_W-1:0] REC_YEAR = REC_W'(183859);

  logic [3:0]  state_q, state_d;
  logic [32:0] secs_ofs;
  logic [6:0]  lo_q;
  logic [15:0] days_q;
  logic [17:0] d_q;
  logic [6:0]  a_q;
  logic [2:0]  b_q;
  logic [8:0]  n_q;
  logic        leap_q;
  logic [8:0]  mrem_q;
  logic [3:0]  mon_q;

  logic [5:0]  second_q, minute_q;
  logic [4:0]  hour_q, dom_q;
  logic [2:0]  weekday_q;
  logic [8:0]  yday_q;
  logic [7:0]  year_q;
  logic [3:0]  month_q;

  div_cmd_t    div_cmd;
  div_sts_t    div_sts;

  es2cd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .sts_o  (div_sts)
  );

  assign secs_ofs = {epoch_seconds_i[31], epoch_seconds_i} + SEC_OFFSET;

  // Year arithmetic once the year count since 1601 is known.
  logic [9:0]  n_plus1;
  logic [2:0]  q100;
  logic        q400;
  logic [17:0] before_days;
  logic [17:0] yday_full;
  logic        leap_calc;

  assign n_plus1 = {1'b0, n_q} + 10'd1;
  assign q100 = {2'b00, (n_q >= 9'd100)} + {2'b00, (n_q >= 9'd200)}
              + {2'b00, (n_q >= 9'd300)} + {2'b00, (n_q >= 9'd400)};
  assign q400 = (n_q >= 9'd400);
  assign before_days = 18'(n_q) * 18'd365 + 18'(n_q[8:2]) - 18'(q100) + 18'(q400);
  assign yday_full = d_q - before_days;
  assign leap_calc = (n_plus1[1:0] == 2'b00) &&
                     !(n_plus1 == 10'd100 || n_plus1 == 10'd200 || n_plus1 == 10'd300);

  // Month scan step.
  logic [4:0] mlen;
  logic       mfits;
  logic [8:0] mrem_next;
  logic       mdone;

  assign mlen      = month_len(mon_q, leap_q);
  assign mfits     = (mrem_q >= 9'(mlen));
  assign mrem_next = mfits ? (mrem_q - 9'(mlen)) : mrem_q;
  assign mdone     = !mfits || (mon_q == MON_DEC);

  always_comb begin
    div_cmd = '0;
    unique case (state_q)
      S_IDLE: begin
        div_cmd.start    = in_valid_i;
        div_cmd.dividend = secs_ofs[32:7];
        div_cmd.divisor  = DSR_DAY;
        div_cmd.recip    = REC_DAY;
      end
      S_DAY: begin
        div_cmd.start    = div_sts.done;
        div_cmd.dividend = DIV_W'({div_sts.rmd[9:0], lo_q});
        div_cmd.divisor  = DSR_60;
        div_cmd.recip    = REC_60;
      end
      S_MIN: begin
        div_cmd.start    = div_sts.done;
        div_cmd.dividend = DIV_W'(div_sts.quot);
        div_cmd.divisor  = DSR_60;
        div_cmd.recip    = REC_60;
      end
      S_HR: begin
        div_cmd.start    = div_sts.done;
        div_cmd.dividend = DIV_W'(days_q) + WD_ADJ;
        div_cmd.divisor  = DSR_WD;
        div_cmd.recip    = REC_WD;
      end
      S_WD: begin
        div_cmd.start    = div_sts.done;
        div_cmd.dividend = DIV_W'(days_q) + DIV_W'(DAY_BASE);
        div_cmd.divisor  = DSR_4Y;
        div_cmd.recip    = REC_4Y;
      end
      S_Y1: begin
        div_cmd.start    = div_sts.done;
        div_cmd.dividend = DIV_W'(d_q);
        div_cmd.divisor  = DSR_100Y;
        div_cmd.recip    = REC_100Y;
      end
      S_Y2: begin
        div_cmd.start    = div_sts.done;
        div_cmd.dividend = DIV_W'(d_q);
        div_cmd.divisor  = DSR_400Y;
        div_cmd.recip    = REC_400Y;
      end
      S_Y3: begin
        div_cmd.start    = div_sts.done;
        div_cmd.dividend = DIV_W'(d_q - 18'(a_q) + 18'(b_q) - 18'(div_sts.quot[0]));
        div_cmd.divisor  = DSR_YEAR;
        div_cmd.recip    = REC_YEAR;
      end
      default: begin
        div_cmd = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i)   state_d = S_DAY;
      S_DAY:  if (div_sts.done) state_d = S_MIN;
      S_MIN:  if (div_sts.done) state_d = S_HR;
      S_HR:   if (div_sts.done) state_d = S_WD;
      S_WD:   if (div_sts.done) state_d = S_Y1;
      S_Y1:   if (div_sts.done) state_d = S_Y2;
      S_Y2:   if (div_sts.done) state_d = S_Y3;
      S_Y3:   if (div_sts.done) state_d = S_Y4;
      S_Y4:   if (div_sts.done) state_d = S_YDAY;
      S_YDAY: state_d = S_MON;
      S_MON:  if (mdone)        state_d = S_OUT;
      S_OUT:  if (out_ready_i)  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        lo_q <= secs_ofs[6:0];
      end
      S_DAY: if (div_sts.done) begin
        days_q <= div_sts.quot;
      end
      S_MIN: if (div_sts.done) begin
        second_q <= div_sts.rmd[5:0];
      end
      S_HR: if (div_sts.done) begin
        hour_q   <= div_sts.quot[4:0];
        minute_q <= div_sts.rmd[5:0];
      end
      S_WD: if (div_sts.done) begin
        weekday_q <= div_sts.rmd[2:0];
        d_q       <= 18'(days_q) + DAY_BASE;
      end
      S_Y1: if (div_sts.done) begin
        a_q <= div_sts.quot[6:0];
      end
      S_Y2: if (div_sts.done) begin
        b_q <= div_sts.quot[2:0];
      end
      S_Y4: if (div_sts.done) begin
        n_q <= div_sts.quot[8:0];
      end
      S_YDAY: begin
        yday_q <= yday_full[8:0];
        mrem_q <= yday_full[8:0];
        // Year 1601 + n minus 1900, kept modulo 256.
        year_q <= 8'(n_q - 9'd299);
        leap_q <= leap_calc;
        mon_q  <= MON_JAN;
      end
      S_MON: begin
        if (mdone) begin
          month_q <= mon_q;
          dom_q   <= 5'(mrem_next + 9'd1);
        end else begin
          mrem_q <= mrem_next;
          mon_q  <= mon_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = (state_q == S_OUT);
  assign second_o           = second_q;
  assign minute_o           = minute_q;
  assign hour_o             = hour_q;
  assign weekday_o          = weekday_q;
  assign day_of_year_o      = yday_q;
  assign years_since_1900_o = year_q;
  assign month_o            = month_q;
  assign day_of_month_o     = dom_q;

endmodule

`default_nettype wire

FILE: rtl/core/es2cd_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Division by a constant through its scaled reciprocal. Since the dividend
// is below 2**REC_SH, the estimate floor(x * recip / 2**REC_SH) is at most
// one below the true quotient, so a single correction step finishes it.
// The one multiplier serves both the estimate and the back-multiply. After
// start come the estimate, back-multiply and correction cycles; done is then
// high for one cycle.
module es2cd_divider
  import es2cd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_cmd_t cmd_i,
  output div_sts_t      sts_o
);

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_EST  = 2'd1;
  localparam logic [1:0] STEP_BACK = 2'd2;
  localparam logic [1:0] STEP_FIX  = 2'd3;

  logic [1:0]             step_q;
  logic                   done_q;
  logic [DIV_W-1:0]       x_q;
  logic [DSR_W-1:0]       dsr_q;
  logic [REC_W-1:0]       rec_q;
  logic [DIV_W-1:0]       quo_q;
  logic [DIV_W-1:0]       rem_q;
  logic [DIV_W-1:0]       mul_a;
  logic [REC_W-1:0]       mul_b;
  logic [DIV_W+REC_W-1:0] mul_p;
  logic                   fits;

  assign mul_a = (step_q == STEP_EST) ? x_q : quo_q;
  assign mul_b = (step_q == STEP_EST) ? rec_q : REC_W'(dsr_q);
  assign mul_p = {{REC_W{1'b0}}, mul_a} * {{DIV_W{1'b0}}, mul_b};
  assign fits  = (rem_q >= DIV_W'(dsr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      done_q <= 1'b0;
    end else if (cmd_i.start) begin
      step_q <= STEP_EST;
      done_q <= 1'b0;
    end else begin
      unique case (step_q)
        STEP_EST: begin
          step_q <= STEP_BACK;
        end
        STEP_BACK: begin
          step_q <= STEP_FIX;
        end
        STEP_FIX: begin
          step_q <= STEP_IDLE;
          done_q <= 1'b1;
        end
        default: begin
          done_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q   <= cmd_i.dividend;
      dsr_q <= cmd_i.divisor;
      rec_q <= cmd_i.recip;
    end else begin
      unique case (step_q)
        STEP_EST: begin
          quo_q <= DIV_W'(mul_p >> REC_SH);
        end
        STEP_BACK: begin
          rem_q <= x_q - mul_p[DIV_W-1:0];
        end
        STEP_FIX: begin
          if (fits) begin
            quo_q <= quo_q + DIV_W'(1);
            rem_q <= rem_q - DIV_W'(dsr_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.quot = quo_q[QUO_W-1:0];
  assign sts_o.rmd  = rem_q[RMD_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/es2cd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module es2cd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [5:0]  second_i,
  input wire logic [5:0]  minute_i,
  input wire logic [4:0]  hour_i,
  input wire logic [2:0]  weekday_i,
  input wire logic [8:0]  day_of_year_i,
  input wire logic [7:0]  years_since_1900_i,
  input wire logic [3:0]  month_i,
  input wire logic [4:0]  day_of_month_i
);

  // A result word, once offered, is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(month_i) && $stable(day_of_year_i))
    else $error("result word dropped or changed while stalled");

  // The block works on one word at a time.
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input accepted while a result is pending");

  // A word just accepted cannot have its result ready on the next cycle.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i && !in_ready_i)
    else $error("result appeared too early after acceptance");

  // Time fields of a result are in range.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> second_i < 6'd60 && minute_i < 6'd60 && hour_i < 5'd24 && weekday_i < 3'd7)
    else $error("time field out of range");

  // Date fields of a result are in range.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> month_i < 4'd12 && day_of_month_i != 5'd0 && day_of_year_i <= 9'd365 &&
                    years_since_1900_i != 8'd0 && years_since_1900_i <= 8'd138)
    else $error("date field out of range");

endmodule

bind epoch_seconds_to_calendar_date_top es2cd_checker u_es2cd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_i         (in_ready_o),
  .out_valid_i        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .second_i           (second_o),
  .minute_i           (minute_o),
  .hour_i             (hour_o),
  .weekday_i          (weekday_o),
  .day_of_year_i      (day_of_year_o),
  .years_since_1900_i (years_since_1900_o),
  .month_i            (month_o),
  .day_of_month_i     (day_of_month_o)
);

`default_nettype wire
